/* rtl/core/min_coin_change_assert.svh */
// ---------------------------------------------------------------------------
// min_coin_change assertion macros
// Short forms for the concurrent checks of the coin change core. They expect
// clk_i and rst_ni in the scope of the module that uses them.
// ---------------------------------------------------------------------------
`ifndef MIN_COIN_CHANGE_ASSERT_SVH
`define MIN_COIN_CHANGE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define MCC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define MCC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define MCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mcc_pkg.sv */
// ---------------------------------------------------------------------------
// mcc_pkg
// Shared types and constants of the minimum coin change core.
// ---------------------------------------------------------------------------
package mcc_pkg;

  // default sizes
  localparam int MAX_COINS_DEF  = 16;
  localparam int MAX_AMOUNT_DEF = 4095;
  localparam int COIN_WIDTH_DEF = 16;

  // fixed field widths
  localparam int KIND_W = 2;
  localparam int VAL_W  = 16;
  localparam int MC_W   = 12;

  // command queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_SOLVE = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // one queued command
  typedef struct packed {
    op_e              op;
    logic [VAL_W-1:0] value;
    logic             too_large;
  } mcc_cmd_t;

endpackage

/* rtl/core/mcc_front.sv */
// ---------------------------------------------------------------------------
// mcc_front
// Accepts input transactions, decodes the kind, flags oversize amounts and
// queues the commands for the back end.
// ---------------------------------------------------------------------------
module mcc_front import mcc_pkg::*; #(
  parameter int MAX_AMOUNT = MAX_AMOUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [VAL_W-1:0]  item_value_i,
  output logic              q_valid_o,
  output mcc_cmd_t          q_cmd_o,
  input  logic              q_pop_i
);

  mcc_cmd_t              fifo_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]     cnt_q, cnt_d;
  logic                  accept;
  logic                  push;
  logic                  known;
  mcc_cmd_t              cmd;

  // decode: kind 3 is accepted and dropped
  always_comb begin
    known     = 1'b1;
    cmd.op    = OP_LOAD;
    cmd.value = item_value_i;
    unique case (kind_i)
      OP_LOAD:  cmd.op = OP_LOAD;
      OP_SOLVE: cmd.op = OP_SOLVE;
      OP_CLEAR: cmd.op = OP_CLEAR;
      default:  known  = 1'b0;
    endcase
    cmd.too_large = (32'(item_value_i) > 32'(MAX_AMOUNT));
  end

  assign busy   = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign accept = start && !busy;
  assign push   = accept && known;

  // queue pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (q_pop_i) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd;
    end
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_cmd_o   = fifo_q[rd_ptr_q];

endmodule

/* rtl/core/mcc_back.sv */
// ---------------------------------------------------------------------------
// mcc_back
// Executes queued commands: keeps the coin store and fills the count table
// bottom-up for each solve, one coin per cycle through a three-stage pipe.
// ---------------------------------------------------------------------------
`include "min_coin_change_assert.svh"

module mcc_back import mcc_pkg::*; #(
  parameter int MAX_COINS  = MAX_COINS_DEF,
  parameter int MAX_AMOUNT = MAX_AMOUNT_DEF,
  parameter int COIN_WIDTH = COIN_WIDTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  mcc_cmd_t        q_cmd_i,
  output logic            q_pop_o,
  output logic            result_valid_o,
  output logic [MC_W-1:0] min_count_o,
  output logic            reachable_o,
  output logic            too_large_o
);

  localparam int AmtW     = $clog2(MAX_AMOUNT + 1);
  localparam int CntW     = AmtW;
  localparam int EntW     = CntW + 1;
  localparam int TabDepth = MAX_AMOUNT + 1;
  localparam int CcW      = $clog2(MAX_COINS + 1);
  localparam int IdxW     = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  localparam int CmpW     = (COIN_WIDTH > AmtW) ? COIN_WIDTH : AmtW;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_INIT  = 5'b00010,
    S_ISSUE = 5'b00100,
    S_DRAIN = 5'b01000,
    S_WRITE = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  logic [CcW-1:0]        coin_count_q, coin_count_d;
  logic [CcW-1:0]        k_q, k_d;
  logic [AmtW-1:0]       i_q, i_d;
  logic [AmtW-1:0]       amount_q, amount_d;
  logic                  have_q, have_d;
  logic [CntW-1:0]       best_q, best_d;
  logic                  valid_b_q, valid_c_q;
  logic                  valid_c_d;
  logic                  issue;

  // memories
  logic [COIN_WIDTH-1:0] coin_mem [MAX_COINS];
  logic [EntW-1:0]       tab_mem [TabDepth];
  logic [COIN_WIDTH-1:0] coin_rd_q;
  logic [EntW-1:0]       tab_rd_q;
  logic                  coin_we;
  logic [COIN_WIDTH-1:0] coin_wd;
  logic                  tab_we;
  logic [AmtW-1:0]       tab_wa;
  logic [EntW-1:0]       tab_wd;
  logic [AmtW-1:0]       tab_ra;

  // datapath helpers
  logic [VAL_W+COIN_WIDTH-1:0] coin_ext;
  logic [CmpW-1:0]       i_cmp, c_cmp, diff;
  logic                  coin_use;
  logic [CntW-1:0]       cand;
  logic [EntW-1:0]       ent_new;
  logic [CntW+MC_W-1:0]  cnt_ext;

  // result register
  logic                  res_valid_q, res_valid_d;
  logic [MC_W-1:0]       res_count_q, res_count_d;
  logic                  res_reach_q, res_reach_d;
  logic                  res_big_q, res_big_d;

  assign coin_ext = {{COIN_WIDTH{1'b0}}, q_cmd_i.value};
  assign coin_wd  = coin_ext[COIN_WIDTH-1:0];
  assign issue    = (state_q == S_ISSUE) && (k_q < coin_count_q);

  // stage B: coin known, pick the table entry it points back to
  assign i_cmp     = CmpW'(i_q);
  assign c_cmp     = CmpW'(coin_rd_q);
  assign coin_use  = (coin_rd_q != '0) && (c_cmp <= i_cmp);
  assign diff      = i_cmp - c_cmp;
  assign tab_ra    = diff[AmtW-1:0];
  assign valid_c_d = valid_b_q && coin_use;

  // stage C: candidate count from the entry read back
  assign cand    = tab_rd_q[EntW-1:1] + CntW'(1);
  assign ent_new = have_q ? {best_q, 1'b1} : '0;
  assign cnt_ext = {{MC_W{1'b0}}, best_q};

  // sequencer
  always_comb begin
    state_d      = state_q;
    coin_count_d = coin_count_q;
    k_d          = k_q;
    i_d          = i_q;
    amount_d     = amount_q;
    have_d       = have_q;
    best_d       = best_q;
    q_pop_o      = 1'b0;
    coin_we      = 1'b0;
    tab_we       = 1'b0;
    tab_wa       = i_q;
    tab_wd       = ent_new;
    res_valid_d  = 1'b0;
    res_count_d  = res_count_q;
    res_reach_d  = res_reach_q;
    res_big_d    = res_big_q;

    // fold a candidate into the running minimum
    if (valid_c_q && tab_rd_q[0] && (!have_q || (cand < best_q))) begin
      best_d = cand;
      have_d = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.op)
            OP_LOAD: begin
              if (coin_count_q < CcW'(MAX_COINS)) begin
                coin_we      = 1'b1;
                coin_count_d = coin_count_q + CcW'(1);
              end
            end
            OP_CLEAR: begin
              coin_count_d = '0;
            end
            default: begin
              if (q_cmd_i.too_large) begin
                res_valid_d = 1'b1;
                res_count_d = '0;
                res_reach_d = 1'b0;
                res_big_d   = 1'b1;
              end else begin
                amount_d = q_cmd_i.value[AmtW-1:0];
                state_d  = S_INIT;
              end
            end
          endcase
        end
      end
      S_INIT: begin
        tab_we = 1'b1;
        tab_wa = '0;
        tab_wd = EntW'(1);
        if (amount_q == '0) begin
          res_valid_d = 1'b1;
          res_count_d = '0;
          res_reach_d = 1'b1;
          res_big_d   = 1'b0;
          state_d     = S_IDLE;
        end else begin
          i_d     = AmtW'(1);
          k_d     = '0;
          have_d  = 1'b0;
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (issue) begin
          k_d = k_q + CcW'(1);
        end else begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!valid_b_q && !valid_c_q) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        tab_we = 1'b1;
        if (i_q == amount_q) begin
          res_valid_d = 1'b1;
          // unreachable amounts report a zero count
          res_count_d = have_q ? cnt_ext[MC_W-1:0] : '0;
          res_reach_d = have_q;
          res_big_d   = 1'b0;
          state_d     = S_IDLE;
        end else begin
          i_d     = i_q + AmtW'(1);
          k_d     = '0;
          have_d  = 1'b0;
          state_d = S_ISSUE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      coin_count_q <= '0;
      valid_b_q    <= 1'b0;
      valid_c_q    <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      coin_count_q <= coin_count_d;
      valid_b_q    <= issue;
      valid_c_q    <= valid_c_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    k_q         <= k_d;
    i_q         <= i_d;
    amount_q    <= amount_d;
    have_q      <= have_d;
    best_q      <= best_d;
    res_count_q <= res_count_d;
    res_reach_q <= res_reach_d;
    res_big_q   <= res_big_d;
  end

  // coin store
  always_ff @(posedge clk_i) begin
    if (coin_we) begin
      coin_mem[coin_count_q[IdxW-1:0]] <= coin_wd;
    end
    coin_rd_q <= coin_mem[k_q[IdxW-1:0]];
  end

  // count table
  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[tab_wa] <= tab_wd;
    end
    tab_rd_q <= tab_mem[tab_ra];
  end

  assign result_valid_o = res_valid_q;
  assign min_count_o    = res_count_q;
  assign reachable_o    = res_reach_q;
  assign too_large_o    = res_big_q;

  // checks
  `MCC_ASSERT_ALWAYS(a_coin_count_max, coin_count_q <= CcW'(MAX_COINS), "coin count overflow")
  `MCC_ASSERT_IMPLIES(a_pipe_in_solve, valid_b_q || valid_c_q,
    state_q == S_ISSUE || state_q == S_DRAIN, "pipe busy outside a solve")
  `MCC_ASSERT_IMPLIES(a_write_range, state_q == S_WRITE,
    i_q != '0 && i_q <= amount_q, "table write beyond the amount")
  `MCC_ASSERT_NEXT(a_pop_idle, q_pop_o && q_cmd_i.op == OP_SOLVE && !q_cmd_i.too_large,
    state_q == S_INIT, "solve did not start")

endmodule

/* rtl/core/min_coin_change.sv */
// ---------------------------------------------------------------------------
// min_coin_change
// Fewest coins for a target amount from a loaded set of denominations,
// solved by bottom-up tabulation.
// ---------------------------------------------------------------------------
// channel   signals                              direction  accepted when
// input     start, busy, kind_i, item_value_i    in         start && !busy
// result    result_valid_o, min_count_o,         out        result_valid_o
//           reachable_o, too_large_o
//
// Loads, clears and oversize solves are done from the idle state of the back
// end as they are popped. A solve walks the count table memory entry by
// entry, one coin per cycle through a coin-read, table-read, compare pipe
// with a drain and write per entry. A two-entry command queue sits between
// the front and the back; busy is high while it is full. Reset is
// asynchronous, active low; the memories are not cleared. The result strobe
// lasts one cycle and cannot be stalled.
// ---------------------------------------------------------------------------
module min_coin_change import mcc_pkg::*; #(
  parameter int MAX_COINS  = MAX_COINS_DEF,
  parameter int MAX_AMOUNT = MAX_AMOUNT_DEF,
  parameter int COIN_WIDTH = COIN_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [VAL_W-1:0]  item_value_i,
  output logic              result_valid_o,
  output logic [MC_W-1:0]   min_count_o,
  output logic              reachable_o,
  output logic              too_large_o
);

  logic     q_valid;
  logic     q_pop;
  mcc_cmd_t q_cmd;

  // accept and decode
  mcc_front #(
    .MAX_AMOUNT (MAX_AMOUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .item_value_i (item_value_i),
    .q_valid_o    (q_valid),
    .q_cmd_o      (q_cmd),
    .q_pop_i      (q_pop)
  );

  // execute
  mcc_back #(
    .MAX_COINS  (MAX_COINS),
    .MAX_AMOUNT (MAX_AMOUNT),
    .COIN_WIDTH (COIN_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_cmd_i        (q_cmd),
    .q_pop_o        (q_pop),
    .result_valid_o (result_valid_o),
    .min_count_o    (min_count_o),
    .reachable_o    (reachable_o),
    .too_large_o    (too_large_o)
  );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the minimum coin change core. A directed table
// covers the boundary cases. Random load, clear and solve sequences
// follow. Every solve result is compared, field by field and in order,
// against a typed directed-row result or an in-bench fewest-coin tabulation.
// ---------------------------------------------------------------------------
module tb_top;
  import mcc_pkg::*;

  localparam int                CYCLE_LIMIT = 3_000_000;
  localparam int                RAND_ITEMS  = 60;
  localparam int                PHASE_LEN   = 15;
  localparam int                MAX_BIG     = 3;
  localparam int                NO_WAY      = -1;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [MC_W-1:0] count;
    logic            reach;
    logic            big;
  } coin_result_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  value;
    logic [4:0]        reps;
    logic              typed;
    coin_result_t      res;
  } dir_row_t;

  localparam int DIR_ROWS = 23;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [KIND_W-1:0] kind_i = OP_LOAD;
  logic [VAL_W-1:0]  item_value_i = '0;
  logic              result_valid_o;
  logic [MC_W-1:0]   min_count_o;
  logic              reachable_o;
  logic              too_large_o;

  // bench copy of the coin store and the solve table
  logic [VAL_W-1:0] held_coins [MAX_COINS_DEF];
  int               held_count = 0;
  int               fewest_tab [MAX_AMOUNT_DEF + 1];

  coin_result_t pending_results [$];
  int           err_count = 0;
  int           cycle_count = 0;
  dir_row_t     dir_rows [DIR_ROWS];

  min_coin_change u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .item_value_i   (item_value_i),
    .result_valid_o (result_valid_o),
    .min_count_o    (min_count_o),
    .reachable_o    (reachable_o),
    .too_large_o    (too_large_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  // fewest coins by bottom-up tabulation over the held coins
  function automatic coin_result_t predict_fewest(input logic [VAL_W-1:0] amount);
    coin_result_t r;
    int           best;
    int           prev;
    r = '0;
    if (amount > MAX_AMOUNT_DEF) begin
      r.big = 1'b1;
      return r;
    end
    fewest_tab[0] = 0;
    for (int i = 1; i <= amount; i++) begin
      best = NO_WAY;
      for (int k = 0; k < held_count; k++) begin
        if (held_coins[k] != 0 && held_coins[k] <= i) begin
          prev = fewest_tab[i - held_coins[k]];
          if (prev != NO_WAY && (best == NO_WAY || prev + 1 < best)) best = prev + 1;
        end
      end
      fewest_tab[i] = best;
    end
    if (fewest_tab[amount] != NO_WAY) begin
      r.count = fewest_tab[amount][MC_W-1:0];
      r.reach = 1'b1;
    end
    return r;
  endfunction

  // one transaction: hold start until accepted, update the predictor,
  // then idle for a random gap
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [VAL_W-1:0] v,
                           input bit typed, input coin_result_t typed_res,
                           input int idle_pct);
    start        <= 1'b1;
    kind_i       <= k;
    item_value_i <= v;
    do @(posedge clk_i); while (busy !== 1'b0);
    case (k)
      OP_LOAD: begin
        if (held_count < MAX_COINS_DEF) begin
          held_coins[held_count] = v;
          held_count++;
        end
      end
      OP_CLEAR: held_count = 0;
      OP_SOLVE: pending_results.push_back(typed ? typed_res : predict_fewest(v));
      default: ;
    endcase
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // result checker: the receiver cannot stall, so sample every strobe
  always @(posedge clk_i) begin
    coin_result_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result, count %0d", min_count_o));
      end else begin
        want = pending_results.pop_front();
        if (min_count_o !== want.count)
          report_mismatch($sformatf("min_count %0d, expected %0d", min_count_o, want.count));
        if (reachable_o !== want.reach)
          report_mismatch($sformatf("reachable %b, expected %b", reachable_o, want.reach));
        if (too_large_o !== want.big)
          report_mismatch($sformatf("too_large %b, expected %b", too_large_o, want.big));
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // pick a coin: mostly small, sometimes zero, sometimes any 16-bit value
  function automatic logic [VAL_W-1:0] pick_coin();
    int roll;
    roll = $urandom_range(7);
    if (roll == 0) return '0;
    if (roll == 1) return VAL_W'($urandom);
    return VAL_W'($urandom_range(40, 1));
  endfunction

  initial begin
    int           items_done;
    int           big_solves;
    int           idle_pct;
    int           n_coins;
    int           n_solves;
    int           roll;
    int           idle_by_phase [4];
    logic [VAL_W-1:0] amount;

    // directed rows: typed results only where obvious
    dir_rows = '{
      '{OP_SOLVE,   16'd0,     5'd1,  1'b1, '{12'd0,    1'b1, 1'b0}}, // amount zero
      '{OP_SOLVE,   16'd1,     5'd1,  1'b1, '{12'd0,    1'b0, 1'b0}}, // empty store
      '{OP_SOLVE,   16'd4095,  5'd1,  1'b1, '{12'd0,    1'b0, 1'b0}}, // empty, top entry
      '{OP_SOLVE,   16'd4096,  5'd1,  1'b1, '{12'd0,    1'b0, 1'b1}}, // just too large
      '{OP_SOLVE,   16'd65535, 5'd1,  1'b1, '{12'd0,    1'b0, 1'b1}},
      '{KIND_UNUSED, 16'd65535, 5'd1, 1'b0, '0},                     // ignored kind
      '{OP_LOAD,    16'd1,     5'd1,  1'b0, '0},
      '{OP_SOLVE,   16'd4095,  5'd1,  1'b1, '{12'd4095, 1'b1, 1'b0}}, // widest count
      '{OP_CLEAR,   16'd0,     5'd1,  1'b0, '0},
      '{OP_LOAD,    16'd0,     5'd1,  1'b0, '0},                     // zero coin
      '{OP_SOLVE,   16'd5,     5'd1,  1'b1, '{12'd0,    1'b0, 1'b0}},
      '{OP_LOAD,    16'd3,     5'd1,  1'b0, '0},
      '{OP_LOAD,    16'd5,     5'd1,  1'b0, '0},
      '{OP_SOLVE,   16'd11,    5'd1,  1'b0, '0},
      '{OP_SOLVE,   16'd7,     5'd1,  1'b0, '0},
      '{OP_LOAD,    16'd65535, 5'd1,  1'b0, '0},
      '{OP_LOAD,    16'd2,     5'd12, 1'b0, '0},                     // fills the store
      '{OP_LOAD,    16'd1,     5'd1,  1'b0, '0},                     // dropped, store full
      '{OP_SOLVE,   16'd1,     5'd1,  1'b0, '0},
      '{OP_SOLVE,   16'd150,   5'd1,  1'b0, '0},
      '{OP_CLEAR,   16'd0,     5'd1,  1'b0, '0},
      '{OP_SOLVE,   16'd0,     5'd1,  1'b1, '{12'd0,    1'b1, 1'b0}},
      '{KIND_UNUSED, 16'd0,    5'd1,  1'b0, '0}
    };
    // idle phases: none, sender 84 %, none, sender 11 %
    idle_by_phase = '{0, 84, 0, 11};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    for (int r = 0; r < DIR_ROWS; r++) begin
      for (int n = 0; n < dir_rows[r].reps; n++)
        send_item(dir_rows[r].kind, dir_rows[r].value, dir_rows[r].typed,
                  dir_rows[r].res, (r % 3 == 1) ? 84 : 0);
    end

    // random part: mostly clear/load/solve sequences, some noise
    items_done = 0;
    big_solves = 0;
    while (items_done < RAND_ITEMS) begin
      idle_pct = idle_by_phase[(items_done / PHASE_LEN) % 4];
      roll     = $urandom_range(9);
      if (roll == 0) begin
        send_item(KIND_UNUSED, VAL_W'($urandom), 1'b0, '0, idle_pct);
      end else if (roll == 1) begin
        // broken sequence: lone load, solve or clear with an oversize value
        send_item(KIND_W'($urandom_range(2)), VAL_W'($urandom_range(65535, 4096)),
                  1'b0, '0, idle_pct);
        items_done++;
      end else begin
        if ($urandom_range(3) != 0) begin
          send_item(OP_CLEAR, VAL_W'($urandom), 1'b0, '0, idle_pct);
          items_done++;
        end
        n_coins = $urandom_range(18, 1);
        for (int c = 0; c < n_coins; c++) begin
          send_item(OP_LOAD, pick_coin(), 1'b0, '0, idle_pct);
          items_done++;
        end
        n_solves = $urandom_range(4, 1);
        for (int s = 0; s < n_solves; s++) begin
          roll = $urandom_range(39);
          if (roll < 5) begin
            amount = VAL_W'($urandom_range(65535, 4096));
          end else if (roll == 5 && big_solves < MAX_BIG) begin
            amount = VAL_W'($urandom_range(4095, 2048));
            big_solves++;
          end else begin
            amount = VAL_W'($urandom_range(250));
          end
          send_item(OP_SOLVE, amount, 1'b0, '0, idle_pct);
          items_done++;
        end
      end
    end
    start <= 1'b0;

    // drain, then allow trailing loads and clears to settle
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
